### rtl/modular_exponentiation_assert.svh
// Assertion macros shared by the modular exponentiation RTL.
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define MODEXP_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("modexp assertion failed");
// Check that a condition never holds outside reset.
`define MODEXP_ASSERT_NEVER(label, clk, rstn, cond) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("modexp forbidden condition seen");
`else
`define MODEXP_ASSERT(label, clk, rstn, prop)
`define MODEXP_ASSERT_NEVER(label, clk, rstn, cond)
`endif

`endif

### rtl/modexp_pkg.sv
// Types and constants for the modular exponentiation block.
package modexp_pkg;

  // Port width of every payload field, the modulus input included
  localparam int DATA_W = 32;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } state_e;

  // Operation running on the shared modular multiplier
  typedef enum logic [1:0] {
    OP_REDUCE,
    OP_MULACC,
    OP_SQUARE
  } op_e;

endpackage

### rtl/modular_exponentiation.sv
// Modular exponentiation by right-to-left square-and-multiply on a bit-serial multiplier.
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+------------------------------
//   input    | in_valid_i / in_stall_o      | base_value_i, exponent_i
//   output   | out_valid_o / out_stall_i    | power_result_o
//   config   | cfg_valid_i / cfg_ready_o    | cfg_modulus_i
//
// One shared interleaved shift-add modular multiplier retires one multiplier bit
// per cycle. An item first reduces the base, then per exponent bit multiplies the
// accumulator on a set bit and squares the base, and ends with the multiply for
// the top set bit; a zero exponent goes straight to the output register.
// Reset clears the sequencer, the output flag and sets the modulus to 1.
// The result sits in an output register; a stalled output holds the block in
// its final state until the register frees, and input is taken only when idle.

`include "modular_exponentiation_assert.svh"

module modular_exponentiation #(
  parameter int WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [modexp_pkg::DATA_W-1:0] base_value_i,
  input  logic [modexp_pkg::DATA_W-1:0] exponent_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [modexp_pkg::DATA_W-1:0] power_result_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [modexp_pkg::DATA_W-1:0] cfg_modulus_i
);
  import modexp_pkg::*;

  localparam int                CNT_W    = $clog2(WIDTH);
  localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(WIDTH - 1);
  localparam logic [WIDTH-1:0]  ONE      = WIDTH'(1);

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [WIDTH-1:0]  acc_q, acc_d;
  logic [WIDTH-1:0]  base_q, base_d;
  logic [WIDTH-1:0]  bits_q, bits_d;
  logic [WIDTH-1:0]  exp_q, exp_d;
  logic [WIDTH-1:0]  rem_q, rem_d;
  logic [WIDTH-1:0]  mod_q, mod_d;
  logic [WIDTH-1:0]  result_q, result_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;

  logic [WIDTH:0]    mod_eff;
  logic [WIDTH:0]    dbl, dbl_red, sum, sum_red;
  logic [WIDTH-1:0]  addend;
  logic [WIDTH-1:0]  step_res;
  logic [WIDTH-1:0]  base_in, exp_in;
  logic              op_last, exp_upper_zero, in_fire, out_free, cfg_fire;
  logic              in_run, rem_ok, base_ok, zero_fire;

  // Handshakes
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  assign base_in        = base_value_i[WIDTH-1:0];
  assign exp_in         = exponent_i[WIDTH-1:0];
  assign op_last        = (cnt_q == '0);
  assign exp_upper_zero = (exp_q[WIDTH-1:1] == '0);

  // A zero modulus acts as 2^WIDTH
  assign mod_eff = (mod_q == '0) ? {1'b1, {WIDTH{1'b0}}} : {1'b0, mod_q};

  // Select the added operand of the running product
  always_comb begin
    case (op_q)
      OP_MULACC: addend = acc_q;
      OP_SQUARE: addend = base_q;
      default:   addend = ONE;
    endcase
  end

  // One step of the serial multiplier: double, reduce, add, reduce
  always_comb begin
    dbl      = {rem_q, 1'b0};
    dbl_red  = (dbl >= mod_eff) ? (dbl - mod_eff) : dbl;
    sum      = dbl_red + {1'b0, (bits_q[WIDTH-1] ? addend : {WIDTH{1'b0}})};
    sum_red  = (sum >= mod_eff) ? (sum - mod_eff) : sum;
    step_res = sum_red[WIDTH-1:0];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (exp_in == '0) ? ST_FLUSH : ST_RUN;
        end
      end
      ST_RUN: begin
        if (op_last && (op_q == OP_MULACC) && exp_upper_zero) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and output register updates
  always_comb begin
    op_d        = op_q;
    acc_d       = acc_q;
    base_d      = base_q;
    bits_d      = bits_q;
    exp_d       = exp_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    result_d    = result_q;
    out_valid_d = out_valid_q;
    mod_d       = cfg_fire ? cfg_modulus_i[WIDTH-1:0] : mod_q;

    // Drop the output beat once taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          acc_d  = ONE;
          base_d = base_in;
          bits_d = base_in;
          exp_d  = exp_in;
          rem_d  = '0;
          cnt_d  = CNT_LAST;
          op_d   = OP_REDUCE;
        end
      end
      ST_RUN: begin
        // Advance one multiplier bit
        rem_d  = step_res;
        bits_d = bits_q << 1;
        cnt_d  = cnt_q - CNT_W'(1);
        if (op_last) begin
          rem_d = '0;
          cnt_d = CNT_LAST;
          case (op_q)
            OP_REDUCE: begin
              base_d = step_res;
              bits_d = step_res;
              op_d   = exp_q[0] ? OP_MULACC : OP_SQUARE;
            end
            OP_MULACC: begin
              acc_d  = step_res;
              bits_d = base_q;
              op_d   = OP_SQUARE;
            end
            OP_SQUARE: begin
              base_d = step_res;
              bits_d = step_res;
              exp_d  = exp_q >> 1;
              op_d   = exp_q[1] ? OP_MULACC : OP_SQUARE;
            end
            default: op_d = OP_REDUCE;
          endcase
        end
      end
      ST_FLUSH: begin
        // Load the output register when it is free
        if (out_free) begin
          result_d    = acc_q;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        op_d = OP_REDUCE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_REDUCE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      mod_q       <= ONE;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      mod_q       <= mod_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    base_q   <= base_d;
    bits_q   <= bits_d;
    exp_q    <= exp_d;
    rem_q    <= rem_d;
    result_q <= result_d;
  end

  assign out_valid_o    = out_valid_q;
  assign power_result_o = DATA_W'(result_q);

  // Conditions watched by the checks below
  assign in_run    = (state_q == ST_RUN);
  assign rem_ok    = ({1'b0, rem_q} < mod_eff);
  assign base_ok   = ({1'b0, base_q} < mod_eff);
  assign zero_fire = in_fire && (exp_in == '0);

  // Partial remainder stays reduced during a product
  `MODEXP_ASSERT(a_rem_reduced, clk_i, rst_ni, in_run |-> rem_ok)
  // Base is reduced once the initial reduction is over
  `MODEXP_ASSERT(a_base_reduced, clk_i, rst_ni, (in_run && op_q != OP_REDUCE) |-> base_ok)
  // A zero exponent goes straight to the output with a result of one
  `MODEXP_ASSERT(a_zero_exp, clk_i, rst_ni, zero_fire |=> (state_q == ST_FLUSH && acc_q == ONE))
  // The accumulator is multiplied only on a set exponent bit
  `MODEXP_ASSERT_NEVER(a_mulacc_bit, clk_i, rst_ni, in_run && op_q == OP_MULACC && !exp_q[0])

endmodule

### test/tb_top.sv
// Self-checking testbench for the modular exponentiation block.
module tb_top;

  localparam int W            = modexp_pkg::DATA_W;
  localparam int NUM_ROWS     = 21;
  localparam int HALF_ITEMS   = 48;
  localparam int DRAIN_CYCLES = 2100;
  localparam int MAX_REPORTS  = 10;

  // Kinds of modulus used across the random part
  typedef enum int {
    MOD_WIDE,
    MOD_ONE,
    MOD_TINY,
    MOD_POW2,
    MOD_ANY,
    MOD_ALL_ONES
  } mod_kind_e;

  // One directed row: a modulus write, or a beat with an optional known power
  typedef struct packed {
    bit           set_mod;
    bit           has_power;
    logic [W-1:0] value;
    logic [W-1:0] exponent;
    logic [W-1:0] power;
  } row_t;

  localparam mod_kind_e MOD_PLAN [6] = '{MOD_WIDE, MOD_ONE, MOD_TINY, MOD_POW2, MOD_ANY,
                                         MOD_ALL_ONES};

  row_t rows [NUM_ROWS] = '{
    // modulus is 1 out of reset: zero exponent stays 1, anything else folds to 0
    '{1'b0, 1'b1, 32'd5,          32'd0,          32'd1},
    '{1'b0, 1'b1, 32'd7,          32'd3,          32'd0},
    '{1'b1, 1'b0, 32'hFFFF_FFFF,  32'd0,          32'd0},
    '{1'b0, 1'b1, 32'd0,          32'd0,          32'd1},
    '{1'b0, 1'b1, 32'd0,          32'd5,          32'd0},
    // base equal to the modulus reduces to zero
    '{1'b0, 1'b1, 32'hFFFF_FFFF,  32'd1,          32'd0},
    '{1'b0, 1'b0, 32'hFFFF_FFFE,  32'hFFFF_FFFF,  32'd0},
    '{1'b0, 1'b1, 32'd2,          32'd31,         32'h8000_0000},
    '{1'b0, 1'b0, 32'd2,          32'd32,         32'd0},
    '{1'b0, 1'b0, 32'h1234_5678,  32'hFFFF_FFFF,  32'd0},
    '{1'b0, 1'b0, 32'hA5A5_A5A5,  32'h5A5A_5A5A,  32'd0},
    // parity modulus
    '{1'b1, 1'b0, 32'd2,          32'd0,          32'd0},
    '{1'b0, 1'b1, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'd1},
    '{1'b0, 1'b1, 32'hFFFF_FFFE,  32'd1,          32'd0},
    // prime modulus
    '{1'b1, 1'b0, 32'd1000000007, 32'd0,          32'd0},
    '{1'b0, 1'b0, 32'd3,          32'd1000000006, 32'd0},
    '{1'b0, 1'b1, 32'd1000000007, 32'd7,          32'd0},
    '{1'b0, 1'b0, 32'hFFFF_FFFF,  32'h8000_0000,  32'd0},
    // top-bit power of two
    '{1'b1, 1'b0, 32'h8000_0000,  32'd0,          32'd0},
    '{1'b0, 1'b0, 32'd3,          32'hFFFF_FFFF,  32'd0},
    '{1'b0, 1'b1, 32'h8000_0000,  32'd1,          32'd0}
  };

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         in_valid_i    = 1'b0;
  logic         in_stall_o;
  logic [W-1:0] base_value_i  = '0;
  logic [W-1:0] exponent_i    = '0;
  logic         out_valid_o;
  logic         out_stall_i   = 1'b0;
  logic [W-1:0] power_result_o;
  logic         cfg_valid_i   = 1'b0;
  logic         cfg_ready_o;
  logic [W-1:0] cfg_modulus_i = '0;

  logic [W-1:0] modulus_now = 32'd1;
  logic [W-1:0] power_q [$];
  int           gap_pct     = 0;
  int           stall_pct   = 0;
  int           err_count   = 0;
  int           beat_count  = 0;

  modular_exponentiation #(
    .WIDTH(W)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .base_value_i  (base_value_i),
    .exponent_i    (exponent_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .power_result_o(power_result_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_modulus_i (cfg_modulus_i)
  );

  always #5 clk_i = ~clk_i;

  // Square-and-multiply from the low exponent bit; a zero modulus wraps at 2^W
  function automatic logic [W-1:0] predict_power(input logic [W-1:0] b, input logic [W-1:0] e,
                                                 input logic [W-1:0] m);
    logic [63:0] mm;
    logic [63:0] acc;
    logic [63:0] sq;
    if (e == '0) return W'(1);
    mm  = (m == '0) ? 64'h1_0000_0000 : {32'b0, m};
    sq  = {32'b0, b} % mm;
    acc = 64'd1;
    for (int i = 0; i < W; i++) begin
      if (e[i]) acc = (acc * sq) % mm;
      sq = (sq * sq) % mm;
    end
    return acc[W-1:0];
  endfunction

  function automatic logic [W-1:0] pick_modulus(input mod_kind_e kind);
    case (kind)
      MOD_WIDE:     return $urandom | 32'h8000_0001;
      MOD_ONE:      return 32'd1;
      MOD_TINY:     return $urandom_range(300, 2);
      MOD_POW2:     return 32'd1 << $urandom_range(31, 1);
      MOD_ANY:      return $urandom_range(32'hFFFF_FFFF, 1);
      default:      return 32'hFFFF_FFFF;
    endcase
  endfunction

  // Mostly full-range bases, with some tiny ones and some near the modulus
  function automatic logic [W-1:0] random_base();
    case ($urandom_range(9))
      0:       return $urandom_range(3);
      1:       return modulus_now - $urandom_range(2);
      default: return $urandom;
    endcase
  endfunction

  // Keep most exponents short so the serial multiplier finishes quickly
  function automatic logic [W-1:0] random_exponent();
    int r;
    r = $urandom_range(99);
    if (r < 5)  return '0;
    if (r < 70) return $urandom_range(255);
    if (r < 90) return $urandom & 32'h000F_FFFF;
    return $urandom;
  endfunction

  // Offer one beat after a random gap, hold it until taken, then log its power
  task automatic send_power(input logic [W-1:0] b, input logic [W-1:0] e,
                            input logic [W-1:0] pw);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    base_value_i <= b;
    exponent_i   <= e;
    do @(posedge clk_i); while (in_stall_o);
    power_q.push_back(pw);
  endtask

  // Drain all pending powers, then write the modulus
  task automatic write_modulus(input logic [W-1:0] m);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (power_q.size() != 0);
    cfg_valid_i   <= 1'b1;
    cfg_modulus_i <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    modulus_now = m;
  endtask

  // Check each result beat against the oldest pending power and redraw the stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        beat_count++;
        if (power_q.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("unexpected result beat %0d: power_result=%h", beat_count,
                     power_result_o);
        end else begin
          if (power_result_o !== power_q[0]) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
              $display("result beat %0d: power_result expected %h got %h", beat_count,
                       power_q[0], power_result_o);
          end
          void'(power_q.pop_front());
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    logic [W-1:0] b;
    logic [W-1:0] e;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows
    gap_pct   = 9;
    stall_pct = 75;
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (rows[r].set_mod)
        write_modulus(rows[r].value);
      else if (rows[r].has_power)
        send_power(rows[r].value, rows[r].exponent, rows[r].power);
      else
        send_power(rows[r].value, rows[r].exponent,
                   predict_power(rows[r].value, rows[r].exponent, modulus_now));
    end

    // Random beats in three idling phases, two moduli per phase
    for (int ph = 0; ph < 3; ph++) begin
      gap_pct   = (ph == 0) ? 9 : (ph == 1) ? 75 : 0;
      stall_pct = (ph == 0) ? 75 : (ph == 1) ? 9 : 0;
      for (int half = 0; half < 2; half++) begin
        write_modulus(pick_modulus(MOD_PLAN[ph * 2 + half]));
        repeat (HALF_ITEMS) begin
          b = random_base();
          e = random_exponent();
          send_power(b, e, predict_power(b, e, modulus_now));
        end
      end
    end

    // Drop valid, wait out the pending powers and a quiet tail
    in_valid_i <= 1'b0;
    while (power_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0 && power_q.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // Bound the run well past the slowest legal schedule
  initial begin
    #40_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/modexp_pkg.sv
rtl/modular_exponentiation.sv
test/tb_top.sv
